@@ rtl/cnbu_pkg.sv @@
// Package for the named-barrier unit: sizes, codes, payload words and the
// per-slot record type. No dependencies.
package cnbu_pkg;

  localparam int unsigned BARRIER_SLOTS = 16;
  localparam int unsigned MAX_WARPS     = 32;

  localparam int unsigned SLOT_IDX_W = (BARRIER_SLOTS > 1) ? $clog2(BARRIER_SLOTS) : 1;
  localparam int unsigned WARP_CNT_W = 6;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned GEN_W      = 64;

  typedef enum logic [1:0] {
    KIND_ARRIVE = 2'd0,
    KIND_RETIRE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_RANGE   = 2'd1,
    ERR_COUNT   = 2'd2,
    ERR_RETIRED = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  barrier_slot;
    logic [4:0]  warp_index;
    logic [7:0]  participant_count;
    logic [63:0] seen_generation;
  } cnbu_in_t;

  typedef struct packed {
    logic        barrier_completed;
    logic        is_released;
    logic [63:0] current_generation;
    logic [1:0]  error_code;
  } cnbu_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]  arrivals;
    logic [CNT_W-1:0]  expected;
    logic              tracks_live;
    logic [MASK_W-1:0] arrived_mask;
    logic [GEN_W-1:0]  generation;
  } slot_rec_t;

endpackage

@@ rtl/cta_named_barrier_unit.sv @@
// Named-barrier unit top level: slot records, live-warp state and the
// sequencer around one shared slot-update unit. Depends on cnbu_pkg.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / in_word_i) takes one word per
//   operation: arrive, retire warp or query. Output channel (out_valid_o /
//   out_ready_i / out_word_o) returns exactly one result word per input word,
//   in order.
//   The block handles one word at a time. Arrive, query and the unused kind
//   pass through the execute and finish steps; retire adds a walk between
//   them that runs every slot record through the single update unit, one
//   slot per cycle. in_ready_o is high only while the sequencer is idle, so
//   a new word can be taken in the cycle after the result is loaded, even if
//   that result is still waiting on the receiver, but not before the result
//   of the last word is loaded.
//   Receiver stall: the result is held in the output register; a finished
//   operation waits in its final step until that register is free.
//   Configuration: cfg_we_i with cfg_wdata_i sets the warp count (0 reads as
//   1, values above MAX_WARPS clamp) and starts a new block: live mask set,
//   every slot cleared, all in the same cycle. Write only while idle.
//   Reset: warp count 32, all warps live, all slots zero, no result pending.
module cta_named_barrier_unit
  import cnbu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [WARP_CNT_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cnbu_in_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cnbu_out_t             out_word_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [SLOT_IDX_W-1:0]   walk_q, walk_d;
  logic [WARP_CNT_W-1:0]   warps_q;
  logic [MASK_W-1:0]       live_q, live_d;
  logic [WARP_CNT_W-1:0]   live_cnt_q, live_cnt_d;
  slot_rec_t               rec_q [BARRIER_SLOTS];

  cnbu_in_t                req_q;
  logic                    done_q, done_d;
  logic                    rel_q, rel_d;
  logic [1:0]              err_q, err_d;
  logic                    out_valid_q, out_valid_d;
  cnbu_out_t               out_q, out_d;

  // Shared update unit signals
  logic [SLOT_IDX_W-1:0]   idx;
  slot_rec_t               cur;
  slot_rec_t               released;
  slot_rec_t               arrive_rec;
  slot_rec_t               walk_rec;
  slot_rec_t               rec_wdata;
  logic                    rec_we;
  logic [MASK_W-1:0]       warp_onehot;
  logic                    slot_ok;
  logic                    warp_bad;
  logic                    out_free;
  logic                    walk_last;

  // Arrive path
  logic                    a_first;
  logic                    a_cnt_zero;
  logic [CNT_W-1:0]        a_exp;
  logic                    a_trk;
  logic                    a_err_count;
  logic [CNT_W-1:0]        a_arr;
  logic                    a_rel;

  // Retire walk path
  logic                    w_dec;
  logic [CNT_W-1:0]        w_exp;
  logic                    w_rel;

  // Configuration decode
  logic [WARP_CNT_W-1:0]   cfg_n;
  logic [MASK_W-1:0]       cfg_ones;

  // --------------------------------------------------------------------------
  // Configuration decode: clamp the warp count, build the live mask
  // --------------------------------------------------------------------------
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_n = WARP_CNT_W'(1);
    end else if (cfg_wdata_i > WARP_CNT_W'(MAX_WARPS)) begin
      cfg_n = WARP_CNT_W'(MAX_WARPS);
    end else begin
      cfg_n = cfg_wdata_i;
    end
    for (int i = 0; i < MASK_W; i++) begin
      cfg_ones[i] = (i < int'(cfg_n));
    end
  end

  // --------------------------------------------------------------------------
  // Shared slot-update unit: one record read at idx, both candidate updates
  // --------------------------------------------------------------------------
  assign idx         = (state_q == ST_WALK) ? walk_q : SLOT_IDX_W'(req_q.barrier_slot);
  assign cur         = rec_q[idx];
  assign warp_onehot = MASK_W'(1) << req_q.warp_index;
  assign slot_ok     = (32'(req_q.barrier_slot) < BARRIER_SLOTS);
  assign warp_bad    = ({1'b0, req_q.warp_index} >= warps_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign walk_last   = (walk_q == SLOT_IDX_W'(BARRIER_SLOTS - 1));

  always_comb begin
    released              = '0;
    released.generation   = cur.generation + GEN_W'(1);

    // Arrive: first arrival fixes the expected count and the tracking mode
    a_first     = (cur.arrivals == '0) && (cur.expected == '0);
    a_cnt_zero  = (req_q.participant_count == '0);
    a_exp       = a_first ? (a_cnt_zero ? CNT_W'(live_cnt_q) : req_q.participant_count)
                          : cur.expected;
    a_trk       = a_first ? a_cnt_zero : cur.tracks_live;
    a_err_count = !a_first && !a_cnt_zero && (cur.expected != req_q.participant_count);
    a_arr       = cur.arrivals + CNT_W'(1);
    a_rel       = (a_arr >= a_exp);

    arrive_rec              = cur;
    arrive_rec.arrivals     = a_arr;
    arrive_rec.expected     = a_exp;
    arrive_rec.tracks_live  = a_trk;
    arrive_rec.arrived_mask = a_trk ? (cur.arrived_mask | warp_onehot) : cur.arrived_mask;
    if (a_rel) begin
      arrive_rec = released;
    end

    // Retire walk: drop the retiring warp from live-tracking slots it has
    // not reached, release any slot that is then satisfied
    w_dec = cur.tracks_live && ((cur.arrived_mask & warp_onehot) == '0);
    w_exp = w_dec ? (cur.expected - CNT_W'(1)) : cur.expected;
    w_rel = (w_exp != '0) && (cur.arrivals >= w_exp);

    walk_rec = cur;
    if (cur.expected != '0) begin
      if (w_rel) begin
        walk_rec = released;
      end else begin
        walk_rec.expected = w_exp;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_q.kind == KIND_RETIRE && !warp_bad && live_q[req_q.warp_index]) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o  = 1'b0;
    rec_we      = 1'b0;
    rec_wdata   = cur;
    walk_d      = walk_q;
    live_d      = live_q;
    live_cnt_d  = live_cnt_q;
    done_d      = done_q;
    rel_d       = rel_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_EXEC: begin
        done_d = 1'b0;
        rel_d  = 1'b0;
        err_d  = ERR_OK;
        case (req_q.kind)
          KIND_ARRIVE: begin
            if (!slot_ok || warp_bad) begin
              err_d = ERR_RANGE;
            end else if (a_err_count) begin
              err_d = ERR_COUNT;
            end else begin
              rec_we    = 1'b1;
              rec_wdata = arrive_rec;
              done_d    = a_rel;
            end
          end
          KIND_RETIRE: begin
            if (warp_bad) begin
              err_d = ERR_RANGE;
            end else if (!live_q[req_q.warp_index]) begin
              err_d = ERR_RETIRED;
            end else begin
              live_d     = live_q & ~warp_onehot;
              live_cnt_d = live_cnt_q - WARP_CNT_W'(1);
              walk_d     = '0;
            end
          end
          KIND_QUERY: begin
            if (!slot_ok) begin
              err_d = ERR_RANGE;
            end else begin
              rel_d = (cur.generation != req_q.seen_generation);
            end
          end
          default: ;
        endcase
      end
      ST_WALK: begin
        rec_we    = 1'b1;
        rec_wdata = walk_rec;
        walk_d    = walk_q + SLOT_IDX_W'(1);
      end
      ST_FINISH: begin
        // Hold here until the output register can take the result
        if (out_free) begin
          out_valid_d                  = 1'b1;
          out_d.barrier_completed      = done_q;
          out_d.is_released            = rel_q;
          out_d.current_generation     = slot_ok ? cur.generation : '0;
          out_d.error_code             = err_q;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      warps_q     <= WARP_CNT_W'(MAX_WARPS);
      live_q      <= {MASK_W{1'b1}} >> (MASK_W - MAX_WARPS);
      live_cnt_q  <= WARP_CNT_W'(MAX_WARPS);
      for (int s = 0; s < BARRIER_SLOTS; s++) begin
        rec_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // Start a new block
        warps_q    <= cfg_n;
        live_q     <= cfg_ones;
        live_cnt_q <= cfg_n;
        for (int s = 0; s < BARRIER_SLOTS; s++) begin
          rec_q[s] <= '0;
        end
      end else begin
        live_q     <= live_d;
        live_cnt_q <= live_cnt_d;
        if (rec_we) begin
          rec_q[idx] <= rec_wdata;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_word_i;
    end
    done_q <= done_d;
    rel_q  <= rel_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/cnbu_checker.sv @@
// Port-level checker for the named-barrier unit and its bind statement.
// Depends on cnbu_pkg and cta_named_barrier_unit.
module cnbu_checker
  import cnbu_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [WARP_CNT_W-1:0] cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input cnbu_in_t              in_word_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input cnbu_out_t             out_word_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // One word at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while an operation is in flight");

  // A new result only appears at the end of an operation
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result word without an operation in flight");

  // Failed operations report no completion and no release
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.error_code != ERR_OK)
      |-> !out_word_o.barrier_completed && !out_word_o.is_released)
    else $error("flags set on a failed operation");

endmodule

bind cta_named_barrier_unit cnbu_checker u_cnbu_checker (.*);

@@ test/tb.sv @@
// Self-checking bench for cta_named_barrier_unit: walks a directed table of words, then random
// arrive/retire/query traffic over a dozen block sizes, checking each reply against a local model or a pinned one.
// Depends on cnbu_pkg and the RTL of the top level only.
`timescale 1ns / 100ps

module tb;
  import cnbu_pkg::*;

  // The block has no name for kind 3; the bench needs one to drive it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Retire walks all slots; even so, the longest receiver stalls and sender gaps on about
  // 1200 words stay well under a tenth of this limit.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int WORDS_PER_SIZE = 100;

  typedef struct {
    bit          is_cfg;
    logic [5:0]  cfg_value;
    cnbu_in_t    word;
    bit          pinned;
    cnbu_out_t   want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [WARP_CNT_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  cnbu_in_t              in_word_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  cnbu_out_t             out_word_o;

  // Local copy of the block state, advanced on every accepted word and configuration write.
  int          blk_warps;
  logic [31:0] blk_live;
  logic [7:0]  bar_arrivals [BARRIER_SLOTS];
  logic [7:0]  bar_expect   [BARRIER_SLOTS];
  logic        bar_tracks   [BARRIER_SLOTS];
  logic [31:0] bar_arrived  [BARRIER_SLOTS];
  logic [63:0] bar_gen      [BARRIER_SLOTS];

  cnbu_out_t   barrier_replies [$];
  plan_row_t   directed_rows [$];
  int          bad_replies = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 12;
  int          recv_idle_pct = 70;
  bit          in_taken = 1'b0;
  bit          fixed_pending = 1'b0;
  cnbu_out_t   fixed_result = '0;

  cta_named_barrier_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Model of the unit
  // ---------------------------------------------------------------------------------------------

  // Start a new block: clamp the size, mark that many warps live, clear every slot.
  function automatic void start_block(logic [5:0] size);
    int n;
    n = (size == 0) ? 1 : ((size > MAX_WARPS) ? MAX_WARPS : size);
    blk_warps = n;
    blk_live  = (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1);
    for (int s = 0; s < BARRIER_SLOTS; s++) begin
      bar_arrivals[s] = '0;
      bar_expect[s]   = '0;
      bar_tracks[s]   = 1'b0;
      bar_arrived[s]  = '0;
      bar_gen[s]      = '0;
    end
  endfunction

  // Clear a satisfied slot and advance its generation (wraps at 64 bits).
  function automatic void release_barrier(int s);
    bar_arrivals[s] = '0;
    bar_expect[s]   = '0;
    bar_tracks[s]   = 1'b0;
    bar_arrived[s]  = '0;
    bar_gen[s]      = bar_gen[s] + 64'd1;
  endfunction

  // Apply one word to the local state and return the reply it should produce.
  function automatic cnbu_out_t step_barrier_unit(cnbu_in_t w);
    cnbu_out_t   r;
    logic [31:0] warp_onehot;
    int          s;
    r           = '0;
    s           = w.barrier_slot;
    warp_onehot = 32'd1 << w.warp_index;
    case (w.kind)
      KIND_ARRIVE: begin
        if (w.warp_index >= blk_warps) begin
          r.error_code = ERR_RANGE;
        end else if (bar_arrivals[s] == 0 && bar_expect[s] == 0) begin
          // First arrival fixes the count; zero means every live warp, tracked from now on.
          bar_expect[s] = (w.participant_count == 0) ? 8'($countones(blk_live))
                                                     : w.participant_count;
          bar_tracks[s] = (w.participant_count == 0);
        end else if (w.participant_count != 0 && bar_expect[s] != w.participant_count) begin
          r.error_code = ERR_COUNT;
        end
        if (r.error_code == ERR_OK) begin
          bar_arrivals[s] = bar_arrivals[s] + 8'd1;
          if (bar_tracks[s]) bar_arrived[s] = bar_arrived[s] | warp_onehot;
          if (bar_arrivals[s] >= bar_expect[s]) begin
            release_barrier(s);
            r.barrier_completed = 1'b1;
          end
        end
      end
      KIND_RETIRE: begin
        if (w.warp_index >= blk_warps) begin
          r.error_code = ERR_RANGE;
        end else if ((blk_live & warp_onehot) == 0) begin
          r.error_code = ERR_RETIRED;
        end else begin
          blk_live = blk_live & ~warp_onehot;
          // Drop the warp from every tracking slot it has not reached; release any now met.
          for (int t = 0; t < BARRIER_SLOTS; t++) begin
            if (bar_expect[t] != 0) begin
              if (bar_tracks[t] && (bar_arrived[t] & warp_onehot) == 0)
                bar_expect[t] = bar_expect[t] - 8'd1;
              if (bar_expect[t] != 0 && bar_arrivals[t] >= bar_expect[t])
                release_barrier(t);
            end
          end
        end
      end
      KIND_QUERY: begin
        r.is_released = (bar_gen[s] != w.seen_generation);
      end
      default: begin
      end
    endcase
    r.current_generation = bar_gen[s];
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Sampling and checking, all at the rising edge
  // ---------------------------------------------------------------------------------------------

  function automatic void report_bad(string what, cnbu_out_t want, cnbu_out_t got);
    bad_replies++;
    if (bad_replies <= 10)
      $display("%0t %s: done %0b/%0b rel %0b/%0b gen %h/%h err %0d/%0d (want/got)", $realtime,
               what, want.barrier_completed, got.barrier_completed, want.is_released,
               got.is_released, want.current_generation, got.current_generation,
               want.error_code, got.error_code);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) start_block(cfg_wdata_i);
      // Predict on acceptance; a pinned table row supplies its own reply instead.
      if (in_valid_i && in_ready_o) begin
        cnbu_out_t predicted;
        predicted = step_barrier_unit(in_word_i);
        barrier_replies.insert(barrier_replies.size(),
                               fixed_pending ? fixed_result : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (barrier_replies.size() == 0) begin
          report_bad("reply with none outstanding", '0, out_word_o);
        end else begin
          cnbu_out_t want;
          want = barrier_replies.pop_front();
          if (want.barrier_completed !== out_word_o.barrier_completed ||
              want.is_released !== out_word_o.is_released ||
              want.current_generation !== out_word_o.current_generation ||
              want.error_code !== out_word_o.error_code)
            report_bad("reply mismatch", want, out_word_o);
        end
      end
    end
    // Read by the driver at the next falling edge.
    in_taken = in_valid_i && in_ready_o;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------------------------
  // Driving, all at the falling edge
  // ---------------------------------------------------------------------------------------------

  // Offer one word after a random gap and hold it until taken; valid stays high afterwards so
  // that the next word can follow back to back.
  task automatic send_word(cnbu_in_t w, bit pinned, cnbu_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_word_i     <= w;
    in_valid_i    <= 1'b1;
    fixed_pending <= pinned;
    fixed_result  <= want;
    do @(negedge clk_i); while (!in_taken);
  endtask

  // Let every outstanding reply drain, then write the block size while the unit is idle.
  task automatic write_block_size(logic [5:0] size);
    in_valid_i <= 1'b0;
    while (barrier_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata_i <= size;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic cnbu_in_t make_word(logic [1:0] kind, int slot, int warp, int cnt,
                                         logic [63:0] seen);
    cnbu_in_t w;
    w.kind              = kind;
    w.barrier_slot      = 4'(slot);
    w.warp_index        = 5'(warp);
    w.participant_count = 8'(cnt);
    w.seen_generation   = seen;
    return w;
  endfunction

  function automatic cnbu_out_t make_reply(bit done, bit rel, logic [63:0] gen,
                                           logic [1:0] err);
    cnbu_out_t r;
    r.barrier_completed  = done;
    r.is_released        = rel;
    r.current_generation = gen;
    r.error_code         = err;
    return r;
  endfunction

  function automatic plan_row_t model_row(cnbu_in_t w);
    return '{is_cfg: 1'b0, cfg_value: '0, word: w, pinned: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t pinned_row(cnbu_in_t w, cnbu_out_t want);
    return '{is_cfg: 1'b0, cfg_value: '0, word: w, pinned: 1'b1, want: want};
  endfunction

  function automatic plan_row_t size_row(logic [5:0] size);
    return '{is_cfg: 1'b1, cfg_value: size, word: '0, pinned: 1'b0, want: '0};
  endfunction

  // Append a row to the end of the directed table.
  function automatic void add_row(plan_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Random traffic biased towards barriers that actually complete: mostly in-range warps, a
  // few busy slots, and counts that agree with what the slot already expects.
  function automatic cnbu_in_t random_word();
    cnbu_in_t w;
    int       pick;
    int       s;
    w.kind              = KIND_ARRIVE;
    w.seen_generation   = {$urandom, $urandom};
    w.participant_count = 8'($urandom);
    w.warp_index = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(blk_warps - 1));
    w.barrier_slot = ($urandom_range(9) < 6) ? 4'($urandom_range(3)) : 4'($urandom);
    s    = w.barrier_slot;
    pick = $urandom_range(99);
    if (pick < 62) begin
      pick = $urandom_range(99);
      if (pick < 45)
        w.participant_count = '0;
      else if (pick < 85)
        w.participant_count = (bar_expect[s] != 0) ? bar_expect[s] : 8'($urandom_range(1, 6));
      else if (pick < 97)
        w.participant_count = 8'($urandom_range(1, 40));
    end else if (pick < 68) begin
      w.kind = KIND_RETIRE;
    end else if (pick < 96) begin
      w.kind = KIND_QUERY;
      pick   = $urandom_range(99);
      if (pick < 40)
        w.seen_generation = bar_gen[s];
      else if (pick < 70)
        w.seen_generation = bar_gen[s] - 64'd1;
    end else begin
      w.kind = KIND_UNUSED;
    end
    return w;
  endfunction

  initial begin
    logic [5:0] block_sizes [12];
    cnbu_in_t   w;

    start_block(6'd32);
    block_sizes = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd8, 6'd31, 6'd33, 6'd16, 6'd0, 6'd5,
                    6'd32};
    block_sizes[9] = 6'($urandom_range(63));

    // Directed table; replies are typed in where they are obvious, the model covers the rest.
    // Fresh block of 32 warps: queries at both ends of the slot range.
    add_row(pinned_row(make_word(KIND_QUERY, 0, 0, 0, 64'd0),
                       make_reply(0, 0, 64'd0, ERR_OK)));
    add_row(pinned_row(make_word(KIND_QUERY, 15, 31, 255, '1),
                       make_reply(0, 1, 64'd0, ERR_OK)));
    // Largest count, then a differing count on the same slot.
    add_row(pinned_row(make_word(KIND_ARRIVE, 15, 31, 255, '0),
                       make_reply(0, 0, 64'd0, ERR_OK)));
    add_row(pinned_row(make_word(KIND_ARRIVE, 15, 0, 1, '0),
                       make_reply(0, 0, 64'd0, ERR_COUNT)));
    // Single-warp barrier releases on its only arrival.
    add_row(pinned_row(make_word(KIND_ARRIVE, 0, 0, 1, '1),
                       make_reply(1, 0, 64'd1, ERR_OK)));
    add_row(pinned_row(make_word(KIND_QUERY, 0, 0, 0, 64'd0),
                       make_reply(0, 1, 64'd1, ERR_OK)));
    // Unused kind reports only the generation.
    add_row(pinned_row(make_word(KIND_UNUSED, 0, 31, 255, '1),
                       make_reply(0, 0, 64'd1, ERR_OK)));
    // Live-tracking slot, then a retire that shrinks it, then the same warp retired twice.
    add_row(model_row(make_word(KIND_ARRIVE, 1, 3, 0, '0)));
    add_row(model_row(make_word(KIND_RETIRE, 1, 5, 0, '0)));
    add_row(pinned_row(make_word(KIND_RETIRE, 2, 5, 0, '0),
                       make_reply(0, 0, 64'd0, ERR_RETIRED)));
    // Block of two warps: warps beyond the block are refused.
    add_row(size_row(6'd2));
    add_row(pinned_row(make_word(KIND_ARRIVE, 2, 2, 0, '0),
                       make_reply(0, 0, 64'd0, ERR_RANGE)));
    add_row(pinned_row(make_word(KIND_RETIRE, 0, 31, 0, '0),
                       make_reply(0, 0, 64'd0, ERR_RANGE)));
    // A retire that completes a tracking slot, then no live warps at all.
    add_row(model_row(make_word(KIND_ARRIVE, 3, 0, 0, '0)));
    add_row(model_row(make_word(KIND_RETIRE, 3, 1, 0, '0)));
    add_row(model_row(make_word(KIND_QUERY, 3, 0, 0, 64'd1)));
    add_row(model_row(make_word(KIND_RETIRE, 0, 0, 0, '0)));
    // A retired warp arrives with nobody live: the slot releases at once.
    add_row(pinned_row(make_word(KIND_ARRIVE, 4, 1, 0, '0),
                       make_reply(1, 0, 64'd1, ERR_OK)));
    // Size zero reads as one warp.
    add_row(size_row(6'd0));
    add_row(model_row(make_word(KIND_ARRIVE, 5, 0, 2, '0)));
    add_row(model_row(make_word(KIND_ARRIVE, 5, 0, 0, '0)));
    // Oversized block clamps to the maximum and clears every generation.
    add_row(size_row(6'd63));
    add_row(pinned_row(make_word(KIND_QUERY, 5, 0, 0, 64'd0),
                       make_reply(0, 0, 64'd0, ERR_OK)));
    add_row(model_row(make_word(KIND_ARRIVE, 7, 31, 0, '0)));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_block_size(directed_rows[i].cfg_value);
      else
        send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].want);
    end

    // Random traffic: a new block size every phase; sender-light then receiver-light idling,
    // then none.
    for (int ph = 0; ph < 12; ph++) begin
      write_block_size(block_sizes[ph]);
      send_idle_pct = (ph < 4) ? 12 : ((ph < 8) ? 70 : 0);
      recv_idle_pct = (ph < 4) ? 70 : ((ph < 8) ? 12 : 0);
      repeat (WORDS_PER_SIZE) begin
        w = random_word();
        send_word(w, 1'b0, '0);
      end
    end

    // Drop valid, drain, then wait longer than a retire lasts for any stray reply.
    in_valid_i <= 1'b0;
    while (barrier_replies.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    bad_replies += barrier_replies.size();
    if (bad_replies == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/cnbu_pkg.sv
rtl/cta_named_barrier_unit.sv
rtl/cnbu_checker.sv
test/tb.sv
